// ----- src/abr_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the aligned bitmap range allocator.
// No dependencies; every other file of the block imports this package.
package abr_pkg;

   localparam int PFN_W     = 40;
   localparam int NR_W      = 22;
   localparam int CHUNK_W   = 13;
   localparam int PPC_SHIFT = 9;
   localparam int WORD_BITS = 64;
   localparam int BIT_W     = 6;
   localparam int ROW_W     = CHUNK_W - BIT_W;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVAL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_PFN    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_COUNT = 1'b1;

   typedef struct packed {
      logic             rd;
      logic             wr;
      logic             set;
      logic [ROW_W-1:0] row;
      logic [BIT_W-1:0] lo_bit;
      logic [BIT_W-1:0] hi_bit;
   } abr_mem_cmd_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic used;
   } abr_run_ctl_type;

endpackage

// ----- src/abr_bitmap.sv -----
`timescale 1ns / 1ps
// Chunk bitmap memory, one word of chunk bits per row, with a clearing sweep
// after reset and a masked read-modify-write of one row. Uses abr_pkg.
module abr_bitmap import abr_pkg::*; #(
   parameter int ROWS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  abr_mem_cmd_type      cmd,
   output logic [WORD_BITS-1:0] rd_data,
   output logic                 init_done
);

   localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [WORD_BITS-1:0] mem [ROWS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [RAW-1:0]       clr_ff;
   logic [RAW-1:0]       clr_in;
   logic                 init_done_ff;
   logic                 init_done_in;
   logic                 we;
   logic [RAW-1:0]       waddr;
   logic [WORD_BITS-1:0] wdata;
   logic [WORD_BITS-1:0] run_bits;

   function automatic logic [WORD_BITS-1:0] run_mask(input logic [BIT_W-1:0] lo,
                                                    input logic [BIT_W-1:0] hi);
      logic [WORD_BITS-1:0] ones;
      ones = '1;
      return (ones << lo) & (ones >> (BIT_W'(WORD_BITS - 1) - hi));
   endfunction

   always_comb begin
      clr_in       = clr_ff;
      init_done_in = init_done_ff;
      if (!init_done_ff) begin
         if (clr_ff == RAW'(ROWS - 1)) begin
            init_done_in = 1'b1;
         end else begin
            clr_in = clr_ff + 1'b1;
         end
      end
   end

   always_comb begin
      run_bits = run_mask(cmd.lo_bit, cmd.hi_bit);
      if (!init_done_ff) begin
         we    = 1'b1;
         waddr = clr_ff;
         wdata = '0;
      end else begin
         we    = cmd.wr;
         waddr = cmd.row[RAW-1:0];
         wdata = cmd.set ? (rd_data_ff | run_bits) : (rd_data_ff & ~run_bits);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         init_done_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         init_done_ff <= init_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[cmd.row[RAW-1:0]];
      end
   end

   assign rd_data   = rd_data_ff;
   assign init_done = init_done_ff;

endmodule

// ----- src/abr_run_unit.sv -----
`timescale 1ns / 1ps
// Free-run tracker: counts consecutive free chunks one chunk per step and
// flags the first chunk that closes an aligned free run. Uses abr_pkg.
module abr_run_unit import abr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  abr_run_ctl_type    ctl,
   input  logic [CHUNK_W-1:0] chunk_idx,
   input  logic [CHUNK_W-1:0] len_mask,
   input  logic [CHUNK_W-1:0] align_off,
   output logic               hit
);

   logic [CHUNK_W-1:0] run_ff;
   logic [CHUNK_W-1:0] run_in;
   logic [CHUNK_W-1:0] start_sum;
   logic               long_enough;
   logic               aligned;

   always_comb begin
      long_enough = run_ff >= len_mask;
      start_sum   = chunk_idx - len_mask + align_off;
      aligned     = (start_sum & len_mask) == '0;
      hit         = ctl.step && !ctl.used && long_enough && aligned;
      run_in      = run_ff;
      if (ctl.clear) begin
         run_in = '0;
      end else if (ctl.step) begin
         if (ctl.used) begin
            run_in = '0;
         end else if (!long_enough) begin
            run_in = run_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

endmodule

// ----- src/aligned_bitmap_range_allocator.sv -----
`timescale 1ns / 1ps
// Top level of the aligned bitmap range allocator: registers, sequencer and
// result port. Uses abr_pkg, abr_bitmap and abr_run_unit.
//
// After reset is released the block is busy in S_INIT while it clears all ROWS
// words of the bitmap (ROWS = bitmap depth rounded up to 64-chunk words, 64 at
// the default size); csr writes are taken at any time. A request is taken when
// start is high and busy is low, and exactly one result is shown on rsp_valid
// for one cycle, the first cycle with busy low again; it cannot be held off. An
// allocation examines one chunk per cycle in the run tracker, except in the
// S_SCAN_RD state that reads each 64-chunk word, then reads and writes back
// each word of the chosen run (S_MARK_RD, S_MARK_WR). The scan stops at the
// last chunk of the first aligned free run, or at the last chunk of the range
// when there is no space. A free clears the bits of its chunks the same way; a
// rejected request, an allocation from an empty range or a free of less than
// one chunk goes from S_CHECK straight to S_DONE.
module aligned_bitmap_range_allocator import abr_pkg::*; #(
   parameter int MAX_CHUNKS = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_op,
   input  logic [NR_W-1:0]      req_nr_pages,
   input  logic [PFN_W-1:0]     req_free_pfn,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [PFN_W-1:0]     rsp_alloc_pfn,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PFN_W-1:0]     csr_wdata
);

   localparam int CHUNK_LIMIT  = (1 << CHUNK_W) - 1;
   localparam int DEPTH_CHUNKS = (MAX_CHUNKS < CHUNK_LIMIT) ? MAX_CHUNKS : CHUNK_LIMIT;
   localparam int ROWS         = (DEPTH_CHUNKS + WORD_BITS - 1) / WORD_BITS;
   localparam logic [CHUNK_W-1:0] DEPTH_C = CHUNK_W'(DEPTH_CHUNKS);

   typedef enum logic [7:0] {
      S_INIT     = 8'b0000_0001,
      S_IDLE     = 8'b0000_0010,
      S_CHECK    = 8'b0000_0100,
      S_SCAN_RD  = 8'b0000_1000,
      S_SCAN_BIT = 8'b0001_0000,
      S_MARK_RD  = 8'b0010_0000,
      S_MARK_WR  = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [PFN_W-1:0]    base_pfn_ff, base_pfn_in;
   logic [CHUNK_W-1:0]  chunk_count_ff, chunk_count_in;
   logic                op_ff, op_in;
   logic [NR_W-1:0]     nr_ff, nr_in;
   logic [PFN_W-1:0]    pfn_ff, pfn_in;
   logic [CHUNK_W-1:0]  size_ff, size_in;
   logic [PFN_W:0]      end_ff, end_in;
   logic [PFN_W:0]      lim_ff, lim_in;
   logic [NR_W-1:0]     diff_ff, diff_in;
   logic [CHUNK_W-1:0]  mask_ff, mask_in;
   logic [CHUNK_W-1:0]  off_ff, off_in;
   logic [CHUNK_W-1:0]  k_ff, k_in;
   logic [CHUNK_W-1:0]  lo_ff, lo_in;
   logic [CHUNK_W-1:0]  hi_ff, hi_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                set_ff, set_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PFN_W-1:0]    rsp_pfn_ff, rsp_pfn_in;

   logic [CHUNK_W-1:0]   eff_chunks;
   logic [CHUNK_W-1:0]   cnt;
   logic [NR_W-1:0]      nr_low_mask;
   logic [NR_W-1:0]      align_bits;
   logic [CHUNK_W-1:0]   run_start;
   logic                 accept;
   logic                 init_done;
   logic                 hit;
   logic [WORD_BITS-1:0] rd_data;
   abr_mem_cmd_type      mem_cmd;
   abr_run_ctl_type      run_ctl;

   abr_bitmap #(
      .ROWS(ROWS)
   ) u_bitmap (
      .clock    (clock),
      .reset    (reset),
      .cmd      (mem_cmd),
      .rd_data  (rd_data),
      .init_done(init_done)
   );

   abr_run_unit u_run (
      .clock    (clock),
      .reset    (reset),
      .ctl      (run_ctl),
      .chunk_idx(k_ff),
      .len_mask (mask_ff),
      .align_off(off_ff),
      .hit      (hit)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign cnt       = nr_ff[NR_W-1:PPC_SHIFT];
   assign nr_low_mask = nr_ff - 1'b1;
   assign align_bits  = base_pfn_ff[NR_W-1:0] & nr_low_mask;
   assign run_start   = k_ff - mask_ff;

   always_comb begin
      eff_chunks     = (chunk_count_ff > DEPTH_C) ? DEPTH_C : chunk_count_ff;
      base_pfn_in    = base_pfn_ff;
      chunk_count_in = chunk_count_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_BASE_PFN) begin
            base_pfn_in = csr_wdata;
         end else if (csr_index == CSR_CHUNK_COUNT) begin
            chunk_count_in = csr_wdata[CHUNK_W-1:0];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      nr_in         = nr_ff;
      pfn_in        = pfn_ff;
      size_in       = size_ff;
      end_in        = end_ff;
      lim_in        = lim_ff;
      diff_in       = diff_ff;
      mask_in       = mask_ff;
      off_in        = off_ff;
      k_in          = k_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      row_in        = row_ff;
      set_in        = set_ff;
      status_in     = status_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pfn_in    = rsp_pfn_ff;
      mem_cmd       = '0;
      run_ctl       = '0;
      run_ctl.used  = rd_data[k_ff[BIT_W-1:0]];

      case (state_ff)
         S_INIT: begin
            if (init_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               nr_in    = req_nr_pages;
               pfn_in   = req_free_pfn;
               size_in  = eff_chunks;
               end_in   = {1'b0, req_free_pfn} + (PFN_W + 1)'(req_nr_pages);
               lim_in   = {1'b0, base_pfn_ff}
                        + (PFN_W + 1)'({eff_chunks, {PPC_SHIFT{1'b0}}});
               diff_in  = req_free_pfn[NR_W-1:0] - base_pfn_ff[NR_W-1:0];
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (op_ff == OP_FREE) begin
               set_in = 1'b0;
               lo_in  = diff_ff[NR_W-1:PPC_SHIFT];
               hi_in  = diff_ff[NR_W-1:PPC_SHIFT] + cnt - 1'b1;
               row_in = diff_ff[NR_W-1:PPC_SHIFT+BIT_W];
               if ((pfn_ff < base_pfn_ff) || (end_ff > lim_ff)) begin
                  status_in = ST_INVAL;
                  state_in  = S_DONE;
               end else if (cnt == '0) begin
                  status_in = ST_OK;
                  state_in  = S_DONE;
               end else begin
                  status_in = ST_OK;
                  state_in  = S_MARK_RD;
               end
            end else begin
               set_in        = 1'b1;
               mask_in       = cnt - 1'b1;
               off_in        = align_bits[NR_W-1:PPC_SHIFT];
               k_in          = '0;
               run_ctl.clear = 1'b1;
               if ((nr_ff == '0) || (nr_ff[PPC_SHIFT-1:0] != '0)) begin
                  status_in = ST_INVAL;
                  state_in  = S_DONE;
               end else if (size_ff == '0) begin
                  status_in = ST_NOSPACE;
                  state_in  = S_DONE;
               end else begin
                  status_in = ST_OK;
                  state_in  = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            mem_cmd.rd  = 1'b1;
            mem_cmd.row = k_ff[CHUNK_W-1:BIT_W];
            state_in    = S_SCAN_BIT;
         end
         S_SCAN_BIT: begin
            run_ctl.step = 1'b1;
            if (hit) begin
               lo_in    = run_start;
               hi_in    = k_ff;
               row_in   = run_start[CHUNK_W-1:BIT_W];
               state_in = S_MARK_RD;
            end else if (k_ff == size_ff - 1'b1) begin
               status_in = ST_NOSPACE;
               state_in  = S_DONE;
            end else begin
               k_in = k_ff + 1'b1;
               if (k_ff[BIT_W-1:0] == '1) begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_MARK_RD: begin
            mem_cmd.rd  = 1'b1;
            mem_cmd.row = row_ff;
            state_in    = S_MARK_WR;
         end
         S_MARK_WR: begin
            mem_cmd.wr     = 1'b1;
            mem_cmd.set    = set_ff;
            mem_cmd.row    = row_ff;
            mem_cmd.lo_bit = (row_ff == lo_ff[CHUNK_W-1:BIT_W]) ? lo_ff[BIT_W-1:0] : '0;
            mem_cmd.hi_bit = (row_ff == hi_ff[CHUNK_W-1:BIT_W]) ? hi_ff[BIT_W-1:0] : '1;
            if (row_ff == hi_ff[CHUNK_W-1:BIT_W]) begin
               state_in = S_DONE;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = S_MARK_RD;
            end
         end
         S_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            if ((op_ff == OP_ALLOC) && (status_ff == ST_OK)) begin
               rsp_pfn_in = base_pfn_ff + PFN_W'({lo_ff, {PPC_SHIFT{1'b0}}});
            end else begin
               rsp_pfn_in = '0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         base_pfn_ff    <= '0;
         chunk_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         base_pfn_ff    <= base_pfn_in;
         chunk_count_ff <= chunk_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      nr_ff         <= nr_in;
      pfn_ff        <= pfn_in;
      size_ff       <= size_in;
      end_ff        <= end_in;
      lim_ff        <= lim_in;
      diff_ff       <= diff_in;
      mask_ff       <= mask_in;
      off_ff        <= off_in;
      k_ff          <= k_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      row_ff        <= row_in;
      set_ff        <= set_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pfn_ff    <= rsp_pfn_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_alloc_pfn = rsp_pfn_ff;

endmodule
